>>> sv/pwlm_pkg.sv
package pwlm_pkg;

    // Significant bits of pixel and window levels; wider settings keep all 16 port bits.
    localparam int PIXEL_BITS = 16;
    localparam int PIX_W = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;
    localparam logic [16:0] PIX_MASK_W = (17'd1 << PIX_W) - 17'd1;
    localparam logic [15:0] PIX_MASK = PIX_MASK_W[15:0];

    // Largest image dimension honored by the mirror logic.
    localparam int MAX_DIM = 4096;
    localparam logic [16:0] MAX_DIM_W = 17'(MAX_DIM);

    // Fraction bits of the log2 and quotient bits of the root-path division.
    localparam int ITER_STEPS = 16;
    // Result bits of the scale-by-255 divider and of the integer root.
    localparam int SCALE_STEPS = 8;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CURVE_LINEAR  = 2'd0,
        CURVE_LOG     = 2'd1,
        CURVE_SQRT    = 2'd2,
        CURVE_SQUARED = 2'd3
    } curve_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WINDOW_LOW   = 3'd0,
        REG_WINDOW_HIGH  = 3'd1,
        REG_CURVE        = 3'd2,
        REG_MIRROR_H     = 3'd3,
        REG_MIRROR_V     = 3'd4,
        REG_IMAGE_WIDTH  = 3'd5,
        REG_IMAGE_HEIGHT = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] win_low;
        logic [15:0] win_high;
        curve_t      curve;
        logic        mir_h;
        logic        mir_v;
        logic [12:0] img_w;
        logic [12:0] img_h;
    } cfg_t;

    typedef struct packed {
        logic [11:0] dest_col;
        logic [11:0] dest_row;
        curve_t      curve;
        logic        empty;
        logic [15:0] d;
        logic [15:0] r;
    } base_t;

    typedef struct packed {
        base_t       base;
        logic [31:0] dd;
        logic [31:0] rr;
        logic [31:0] md;
        logic [31:0] mr;
        logic [3:0]  nd;
        logic [3:0]  nr;
        logic [ITER_STEPS-1:0] fd;
        logic [ITER_STEPS-1:0] fr;
        logic [15:0] rem;
        logic [15:0] nlo;
        logic [ITER_STEPS-1:0] quo;
    } iter_t;

    typedef struct packed {
        logic [11:0] dest_col;
        logic [11:0] dest_row;
        curve_t      curve;
        logic        force_en;
        logic [7:0]  force_val;
        logic        big;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] rem;
        logic [7:0]  q;
        logic [15:0] sx;
        logic [7:0]  sr;
    } scale_t;

    typedef struct packed {
        logic [7:0]  display_index;
        logic [11:0] dest_column;
        logic [11:0] dest_row;
    } out_t;

    function automatic logic [16:0] clamp_dim(logic [12:0] s);
        logic [16:0] v;
        v = 17'(s);
        if (v == 17'd0) begin
            v = 17'd1;
        end else if (v > MAX_DIM_W) begin
            v = MAX_DIM_W;
        end
        return v;
    endfunction

    // One squaring step of both logarithms and one quotient bit of the root-path division.
    function automatic iter_t iter_step(iter_t x);
        iter_t       y;
        logic [63:0] pd;
        logic [63:0] pr;
        logic [32:0] qd;
        logic [32:0] qr;
        logic [16:0] t;
        y  = x;
        pd = 64'(x.md) * 64'(x.md);
        pr = 64'(x.mr) * 64'(x.mr);
        qd = pd[63:31];
        qr = pr[63:31];
        if (qd[32]) begin
            y.md = qd[32:1];
            y.fd = {x.fd[ITER_STEPS-2:0], 1'b1};
        end else begin
            y.md = qd[31:0];
            y.fd = {x.fd[ITER_STEPS-2:0], 1'b0};
        end
        if (qr[32]) begin
            y.mr = qr[32:1];
            y.fr = {x.fr[ITER_STEPS-2:0], 1'b1};
        end else begin
            y.mr = qr[31:0];
            y.fr = {x.fr[ITER_STEPS-2:0], 1'b0};
        end
        t = {x.rem, x.nlo[15]};
        if (t >= {1'b0, x.base.r}) begin
            y.rem = 16'(t - {1'b0, x.base.r});
            y.quo = {x.quo[ITER_STEPS-2:0], 1'b1};
        end else begin
            y.rem = t[15:0];
            y.quo = {x.quo[ITER_STEPS-2:0], 1'b0};
        end
        y.nlo = {x.nlo[14:0], 1'b0};
        return y;
    endfunction

    // One bit of floor(256*a/b) and one bit of the integer square root.
    function automatic scale_t scale_step(scale_t x, logic [7:0] bit_m);
        scale_t      y;
        logic [32:0] t;
        logic [7:0]  tt;
        logic [15:0] sq;
        y = x;
        t = {x.rem, 1'b0};
        if (t >= {1'b0, x.b}) begin
            y.rem = 32'(t - {1'b0, x.b});
            y.q   = {x.q[6:0], 1'b1};
        end else begin
            y.rem = t[31:0];
            y.q   = {x.q[6:0], 1'b0};
        end
        tt = x.sr | bit_m;
        sq = 16'(tt) * 16'(tt);
        if (sq <= x.sx) begin
            y.sr = tt;
        end
        return y;
    endfunction

endpackage

>>> sv/pwlm_front.sv
module pwlm_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [15:0]       pixel,
    input  logic [11:0]       column,
    input  logic [11:0]       row,
    input  pwlm_pkg::cfg_t    cfg,
    output logic              out_vld,
    output pwlm_pkg::iter_t   out_data
);

    logic            vld1_reg;
    logic            vld2_reg;
    pwlm_pkg::base_t s1_reg;
    pwlm_pkg::base_t s1_next;
    pwlm_pkg::iter_t s2_reg;
    pwlm_pkg::iter_t s2_next;

    function automatic logic [3:0] lead_one(logic [15:0] x);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) begin
                n = 4'(i);
            end
        end
        return n;
    endfunction

    // Stage 1: clamp to the window, form offset and range, mirror the coordinates.
    always_comb begin
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] p;
        logic [15:0] pc;
        lo = cfg.win_low & pwlm_pkg::PIX_MASK;
        hi = cfg.win_high & pwlm_pkg::PIX_MASK;
        p  = pixel & pwlm_pkg::PIX_MASK;
        if (p < lo) begin
            pc = lo;
        end else if (p > hi) begin
            pc = hi;
        end else begin
            pc = p;
        end
        s1_next.empty = (hi <= lo);
        s1_next.d     = pc - lo;
        s1_next.r     = hi - lo;
        s1_next.curve = cfg.curve;
        s1_next.dest_col = cfg.mir_h ?
            12'(pwlm_pkg::clamp_dim(cfg.img_w) - 17'd1 - 17'(column)) : column;
        s1_next.dest_row = cfg.mir_v ?
            12'(pwlm_pkg::clamp_dim(cfg.img_h) - 17'd1 - 17'(row)) : row;
    end

    // Stage 2: squares, normalized mantissas and the root-path dividend.
    always_comb begin
        logic [31:0] num;
        num          = 32'(s1_reg.d) * 32'd65025;
        s2_next.base = s1_reg;
        s2_next.dd   = 32'(s1_reg.d) * 32'(s1_reg.d);
        s2_next.rr   = 32'(s1_reg.r) * 32'(s1_reg.r);
        s2_next.nd   = lead_one(s1_reg.d);
        s2_next.nr   = lead_one(s1_reg.r);
        s2_next.md   = 32'(s1_reg.d) << (5'd31 - {1'b0, s2_next.nd});
        s2_next.mr   = 32'(s1_reg.r) << (5'd31 - {1'b0, s2_next.nr});
        s2_next.fd   = '0;
        s2_next.fr   = '0;
        s2_next.rem  = num[31:16];
        s2_next.nlo  = num[15:0];
        s2_next.quo  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign out_vld  = vld2_reg;
    assign out_data = s2_reg;

endmodule

>>> sv/pwlm_iter.sv
module pwlm_iter (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_vld,
    input  pwlm_pkg::iter_t in_data,
    output logic            out_vld,
    output pwlm_pkg::iter_t out_data
);

    localparam int N = pwlm_pkg::ITER_STEPS;

    logic [N-1:0]    vld_reg;
    pwlm_pkg::iter_t st_reg  [N];
    pwlm_pkg::iter_t st_next [N];

    always_comb begin
        st_next[0] = pwlm_pkg::iter_step(in_data);
        for (int k = 1; k < N; k++) begin
            st_next[k] = pwlm_pkg::iter_step(st_reg[k-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N-2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign out_data = st_reg[N-1];

endmodule

>>> sv/pwlm_scale.sv
module pwlm_scale (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_vld,
    input  pwlm_pkg::iter_t in_data,
    output logic            out_vld,
    output pwlm_pkg::out_t  out_data
);

    localparam int N = pwlm_pkg::SCALE_STEPS;

    logic             sel_vld_reg;
    pwlm_pkg::scale_t sel_reg;
    pwlm_pkg::scale_t sel_next;
    logic [N-1:0]     vld_reg;
    pwlm_pkg::scale_t st_reg  [N];
    pwlm_pkg::scale_t st_next [N];
    logic             fin_vld_reg;
    pwlm_pkg::out_t   fin_reg;
    pwlm_pkg::out_t   fin_next;

    // Pick divider operands per curve and settle the fixed answers.
    always_comb begin
        logic [31:0] ld;
        logic [31:0] lr;
        ld = 32'({in_data.nd, in_data.fd});
        lr = 32'({in_data.nr, in_data.fr});
        sel_next.dest_col  = in_data.base.dest_col;
        sel_next.dest_row  = in_data.base.dest_row;
        sel_next.curve     = in_data.base.curve;
        sel_next.force_en  = 1'b0;
        sel_next.force_val = 8'd0;
        if (in_data.base.empty) begin
            sel_next.force_en = 1'b1;
        end else if (in_data.base.curve == pwlm_pkg::CURVE_LOG) begin
            if (in_data.base.d == in_data.base.r) begin
                sel_next.force_en  = 1'b1;
                sel_next.force_val = 8'hFF;
            end else if (in_data.base.d <= 16'd1) begin
                sel_next.force_en = 1'b1;
            end
        end
        case (in_data.base.curve)
            pwlm_pkg::CURVE_LOG: begin
                sel_next.a = ld;
                sel_next.b = lr;
            end
            pwlm_pkg::CURVE_SQUARED: begin
                sel_next.a = in_data.dd;
                sel_next.b = in_data.rr;
            end
            pwlm_pkg::CURVE_LINEAR, pwlm_pkg::CURVE_SQRT: begin
                sel_next.a = 32'(in_data.base.d);
                sel_next.b = 32'(in_data.base.r);
            end
        endcase
        sel_next.big = (sel_next.a >= sel_next.b);
        sel_next.rem = sel_next.a;
        sel_next.q   = 8'd0;
        sel_next.sx  = in_data.quo;
        sel_next.sr  = 8'd0;
    end

    always_comb begin
        st_next[0] = pwlm_pkg::scale_step(sel_reg, 8'h80);
        for (int k = 1; k < N; k++) begin
            st_next[k] = pwlm_pkg::scale_step(st_reg[k-1], 8'(8'h80 >> k));
        end
    end

    // floor(255a/b) = floor(256a/b), less one when the remainder is below a.
    always_comb begin
        pwlm_pkg::scale_t x;
        logic [7:0]       sc;
        x = st_reg[N-1];
        if (x.big) begin
            sc = 8'hFF;
        end else if (x.rem >= x.a) begin
            sc = x.q;
        end else begin
            sc = x.q - 8'd1;
        end
        fin_next.dest_column = x.dest_col;
        fin_next.dest_row    = x.dest_row;
        if (x.force_en) begin
            fin_next.display_index = x.force_val;
        end else if (x.curve == pwlm_pkg::CURVE_SQRT) begin
            fin_next.display_index = x.sr;
        end else begin
            fin_next.display_index = sc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_vld_reg <= 1'b0;
            vld_reg     <= '0;
            fin_vld_reg <= 1'b0;
        end else if (en) begin
            sel_vld_reg <= in_vld;
            vld_reg     <= {vld_reg[N-2:0], sel_vld_reg};
            fin_vld_reg <= vld_reg[N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel_reg <= sel_next;
            for (int k = 0; k < N; k++) begin
                st_reg[k] <= st_next[k];
            end
            fin_reg <= fin_next;
        end
    end

    assign out_vld  = fin_vld_reg;
    assign out_data = fin_reg;

endmodule

>>> sv/pwlm_outbuf.sv
module pwlm_outbuf (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pwlm_pkg::out_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output pwlm_pkg::out_t head
);

    pwlm_pkg::out_t buf_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = buf_reg[rd_ptr_reg];

endmodule

>>> sv/pixel_window_level_mapper.sv
// Window/level mapper: each pixel word is clamped to [window_low, window_high] and turned
// into an 8-bit display index by a linear, logarithmic, square-root or squared curve,
// while its column and row are optionally mirrored. A new word is accepted every clock
// while the output buffer is not full; each word passes 2 front stages, 16 log/divide
// stages, 10 scale/root stages and 1 output buffer entry, set by the sixteen fraction
// bits of the log2 unit and the eight bits of the scale divider. A two-word output buffer
// holds results while m_tready is low; s_tready drops only when that buffer is full, so
// the input side sees no combinational path from m_tready. Configuration writes take
// effect on the next clock and should be made only while no word is in flight.
module pixel_window_level_mapper (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pixel[15:0], column[27:16], row[39:28]
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // display_index[7:0], dest_column[19:8], dest_row[31:20]
    // Register writes
    input  logic                                 cfg_wr_en,
    input  logic [pwlm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [pwlm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    logic [15:0]      window_low_reg;
    logic [15:0]      window_high_reg;
    pwlm_pkg::curve_t curve_reg;
    logic             mirror_h_reg;
    logic             mirror_v_reg;
    logic [12:0]      image_width_reg;
    logic [12:0]      image_height_reg;
    pwlm_pkg::cfg_t   cfg;

    logic            en;
    logic            front_vld;
    pwlm_pkg::iter_t front_data;
    logic            iter_vld;
    pwlm_pkg::iter_t iter_data;
    logic            scale_vld;
    pwlm_pkg::out_t  scale_data;
    logic            buf_full;
    logic            buf_not_empty;
    pwlm_pkg::out_t  buf_head;

    // Register file: decode the index, ignore unused indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_low_reg   <= 16'd0;
            window_high_reg  <= 16'd0;
            curve_reg        <= pwlm_pkg::CURVE_LINEAR;
            mirror_h_reg     <= 1'b0;
            mirror_v_reg     <= 1'b0;
            image_width_reg  <= 13'd4096;
            image_height_reg <= 13'd4096;
        end else if (cfg_wr_en) begin
            unique case (pwlm_pkg::reg_idx_t'(cfg_addr))
                pwlm_pkg::REG_WINDOW_LOW:   window_low_reg   <= cfg_wdata[15:0];
                pwlm_pkg::REG_WINDOW_HIGH:  window_high_reg  <= cfg_wdata[15:0];
                pwlm_pkg::REG_CURVE:        curve_reg <= pwlm_pkg::curve_t'(cfg_wdata[1:0]);
                pwlm_pkg::REG_MIRROR_H:     mirror_h_reg     <= cfg_wdata[0];
                pwlm_pkg::REG_MIRROR_V:     mirror_v_reg     <= cfg_wdata[0];
                pwlm_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[12:0];
                pwlm_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    assign cfg.win_low  = window_low_reg;
    assign cfg.win_high = window_high_reg;
    assign cfg.curve    = curve_reg;
    assign cfg.mir_h    = mirror_h_reg;
    assign cfg.mir_v    = mirror_v_reg;
    assign cfg.img_w    = image_width_reg;
    assign cfg.img_h    = image_height_reg;

    // Advance the whole pipeline unless the output buffer is full; hold every stage otherwise.
    assign en       = ~buf_full;
    assign s_tready = en;

    pwlm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_tvalid),
        .pixel    (s_tdata[15:0]),
        .column   (s_tdata[27:16]),
        .row      (s_tdata[39:28]),
        .cfg      (cfg),
        .out_vld  (front_vld),
        .out_data (front_data)
    );

    pwlm_iter u_iter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (front_vld),
        .in_data  (front_data),
        .out_vld  (iter_vld),
        .out_data (iter_data)
    );

    pwlm_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (iter_vld),
        .in_data  (iter_data),
        .out_vld  (scale_vld),
        .out_data (scale_data)
    );

    // Drop finished words into the buffer only on an advancing cycle.
    pwlm_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (en & scale_vld),
        .push_data (scale_data),
        .pop       (m_tvalid & m_tready),
        .full      (buf_full),
        .not_empty (buf_not_empty),
        .head      (buf_head)
    );

    assign m_tvalid = buf_not_empty;
    assign m_tdata  = {buf_head.dest_row, buf_head.dest_column, buf_head.display_index};

    // An empty output buffer can never stall the input.
    a_empty_not_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output buffer");

    // The input only stalls after a result was held back downstream.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without downstream backpressure");

endmodule

>>> tb/tb_pixel_window_level_mapper.sv
module tb_pixel_window_level_mapper;

    localparam int PHASES = 10;
    localparam int WORDS_PER_PHASE = 125;
    localparam int DRAIN_CYCLES = 40;

    // Expected display index and destination coordinates, kept in arrival order.
    class mapper_scoreboard;
        logic [15:0]       win_lo, win_hi;
        pwlm_pkg::curve_t  crv;
        logic              mir_h, mir_v;
        logic [12:0]       img_w, img_h;
        pwlm_pkg::out_t    pending[$];
        int                errors;
        int                matched;

        function new();
            reset_regs();
            errors  = 0;
            matched = 0;
        endfunction

        function void reset_regs();
            win_lo = 16'd0;
            win_hi = 16'd0;
            crv    = pwlm_pkg::CURVE_LINEAR;
            mir_h  = 1'b0;
            mir_v  = 1'b0;
            img_w  = 13'd4096;
            img_h  = 13'd4096;
        endfunction

        function void write_reg(pwlm_pkg::reg_idx_t idx, logic [15:0] val);
            case (idx)
                pwlm_pkg::REG_WINDOW_LOW:   win_lo = val;
                pwlm_pkg::REG_WINDOW_HIGH:  win_hi = val;
                pwlm_pkg::REG_CURVE:        crv = pwlm_pkg::curve_t'(val[1:0]);
                pwlm_pkg::REG_MIRROR_H:     mir_h = val[0];
                pwlm_pkg::REG_MIRROR_V:     mir_v = val[0];
                pwlm_pkg::REG_IMAGE_WIDTH:  img_w = val[12:0];
                pwlm_pkg::REG_IMAGE_HEIGHT: img_h = val[12:0];
                default: ;
            endcase
        endfunction

        // floor(255*a/b), saturating at 255 when a reaches b.
        function logic [7:0] times255_over(logic [63:0] a, logic [63:0] b);
            logic [63:0] q;
            if (a >= b) return 8'd255;
            q = (a * 64'd255) / b;
            return q[7:0];
        endfunction

        // log2 in Q8.16 by repeated squaring of the normalized mantissa.
        function logic [63:0] log2_fixed(logic [63:0] x);
            int          n;
            logic [63:0] m, frac;
            n = 0;
            while (n < 31 && (x >> (n + 1)) != 0) n++;
            m    = x << (31 - n);
            frac = 0;
            for (int i = 0; i < 16; i++) begin
                m    = (m * m) >> 31;
                frac = frac << 1;
                if (m[32]) begin
                    frac[0] = 1'b1;
                    m       = m >> 1;
                end
            end
            return (64'(n) << 16) | frac;
        endfunction

        function logic [7:0] int_root(logic [63:0] x);
            logic [7:0] r, t;
            r = 8'd0;
            for (int b = 7; b >= 0; b--) begin
                t = r | (8'd1 << b);
                if (64'(t) * 64'(t) <= x) r = t;
            end
            return r;
        endfunction

        function logic [7:0] level_index(logic [15:0] pix);
            logic [63:0] d, rng;
            if (win_hi <= win_lo) return 8'd0;
            if (pix < win_lo) pix = win_lo;
            else if (pix > win_hi) pix = win_hi;
            d   = 64'(pix - win_lo);
            rng = 64'(win_hi - win_lo);
            case (crv)
                pwlm_pkg::CURVE_LINEAR: return times255_over(d, rng);
                pwlm_pkg::CURVE_LOG: begin
                    if (d == rng) return 8'd255;
                    if (d <= 1) return 8'd0;
                    return times255_over(log2_fixed(d), log2_fixed(rng));
                end
                pwlm_pkg::CURVE_SQRT: return int_root((64'd65025 * d) / rng);
                default: return times255_over(d * d, rng * rng);
            endcase
        endfunction

        function logic [11:0] flip(logic [11:0] c, logic [12:0] size);
            logic [16:0] s;
            s = 17'(size);
            if (s == 0) s = 17'd1;
            else if (s > 17'd4096) s = 17'd4096;
            return 12'(s - 17'd1 - 17'(c));
        endfunction

        function void note_word(logic [39:0] word);
            pwlm_pkg::out_t e;
            e.display_index = level_index(word[15:0]);
            e.dest_column   = mir_h ? flip(word[27:16], img_w) : word[27:16];
            e.dest_row      = mir_v ? flip(word[39:28], img_h) : word[39:28];
            pending.push_back(e);
        endfunction

        function void check_word(logic [31:0] word);
            pwlm_pkg::out_t e, a;
            a = pwlm_pkg::out_t'({word[7:0], word[19:8], word[31:20]});
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h", $time, word);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.display_index !== e.display_index) begin
                $display("%0t: display_index expected %0d actual %0d",
                         $time, e.display_index, a.display_index);
                errors++;
            end
            if (a.dest_column !== e.dest_column) begin
                $display("%0t: dest_column expected %0d actual %0d",
                         $time, e.dest_column, a.dest_column);
                errors++;
            end
            if (a.dest_row !== e.dest_row) begin
                $display("%0t: dest_row expected %0d actual %0d",
                         $time, e.dest_row, a.dest_row);
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [pwlm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [pwlm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    mapper_scoreboard sb = new();
    int sent_words = 0;

    pixel_window_level_mapper dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort on a hang.
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: stall a random number of cycles, then take one word.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) stall = 0;
            @(negedge aclk);
            m_tready = 1'b0;
            repeat (stall) @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_word(m_tdata);
        end
    end

    // Write one register at a falling edge; it lands at the next rising edge.
    task automatic write_reg(pwlm_pkg::reg_idx_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Offer one word after a random gap (none when no_gap is set), hold until accepted.
    task automatic send_word(logic [15:0] pix, logic [11:0] col, logic [11:0] row,
                             bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {row, col, pix};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(s_tdata);
        sent_words++;
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Hold the sender until every expected word is back, then let the pipe empty.
    task automatic drain();
        release_input();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_pixel();
        logic [15:0] span;
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return sb.win_lo - 16'($urandom_range(0, 3));
            2: return sb.win_hi + 16'($urandom_range(0, 3));
            default: begin
                span = sb.win_hi - sb.win_lo;
                if (sb.win_hi <= sb.win_lo) return 16'($urandom);
                return sb.win_lo + 16'($urandom_range(0, span));
            end
        endcase
    endfunction

    function automatic logic [12:0] pick_dim();
        case ($urandom_range(0, 5))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'd4096;
            3: return 13'($urandom_range(4097, 8191));
            default: return 13'($urandom_range(1, 4096));
        endcase
    endfunction

    // Choose the register setting for one phase; early phases are fixed corners.
    task automatic configure_phase(int ph);
        logic [15:0]      lo, hi;
        logic [12:0]      w, h;
        pwlm_pkg::curve_t c;
        case (ph)
            1: begin
                lo = 16'd0;    hi = 16'hFFFF; c = pwlm_pkg::CURVE_LINEAR;
                w = 13'd4096;  h = 13'd1;
            end
            2: begin
                lo = 16'd1000; hi = 16'd1001; c = pwlm_pkg::CURVE_LOG;
                w = 13'd0;     h = 13'd0;
            end
            3: begin
                lo = 16'd0;    hi = 16'hFFFF; c = pwlm_pkg::CURVE_LOG;
                w = 13'd8191;  h = 13'd4096;
            end
            4: begin
                lo = 16'd0;    hi = 16'hFFFF; c = pwlm_pkg::CURVE_SQRT;
                w = 13'd1;     h = 13'd8191;
            end
            5: begin
                lo = 16'd0;    hi = 16'hFFFF; c = pwlm_pkg::CURVE_SQUARED;
                w = 13'd640;   h = 13'd480;
            end
            6: begin
                lo = 16'd5000; hi = 16'd4000; c = pwlm_pkg::CURVE_SQRT;
                w = 13'd100;   h = 13'd100;
            end
            default: begin
                lo = 16'($urandom);
                hi = lo + 16'($urandom_range(1, 65535 - lo));
                if ($urandom_range(0, 3) == 0) begin
                    hi = 16'($urandom_range(1, 300));
                    lo = 16'($urandom_range(0, hi - 1));
                end
                c = pwlm_pkg::curve_t'($urandom_range(0, 3));
                w = pick_dim();
                h = pick_dim();
            end
        endcase
        write_reg(pwlm_pkg::REG_WINDOW_LOW, lo);
        write_reg(pwlm_pkg::REG_WINDOW_HIGH, hi);
        write_reg(pwlm_pkg::REG_CURVE, 16'(c));
        write_reg(pwlm_pkg::REG_MIRROR_H, 16'(ph % 2));
        write_reg(pwlm_pkg::REG_MIRROR_V, 16'((ph / 2) % 2));
        write_reg(pwlm_pkg::REG_IMAGE_WIDTH, 16'(w));
        write_reg(pwlm_pkg::REG_IMAGE_HEIGHT, 16'(h));
    endtask

    initial begin
        bit burst;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            // Phase zero runs on the reset values: empty window, no mirroring.
            if (ph > 0) configure_phase(ph);
            // Window edges, one step inside, and the extreme coordinates.
            send_word(16'h0000, 12'd0, 12'd0, 1'b0);
            send_word(16'hFFFF, 12'hFFF, 12'hFFF, 1'b0);
            send_word(sb.win_lo, 12'hFFF, 12'd0, 1'b1);
            send_word(sb.win_lo + 16'd1, 12'd0, 12'hFFF, 1'b1);
            send_word(sb.win_hi, 12'h555, 12'hAAA, 1'b0);
            send_word(sb.win_hi - 16'd1, 12'hAAA, 12'h555, 1'b0);
            burst = 1'b0;
            for (int i = 6; i < WORDS_PER_PHASE; i++) begin
                // Alternate stretches of back-to-back words with gapped ones.
                if ($urandom_range(0, 15) == 0) burst = !burst;
                send_word(pick_pixel(), 12'($urandom), 12'($urandom), burst);
            end
            drain();
        end

        $display("covered %0d words over %0d register settings, %0d results checked",
                 sent_words, PHASES, sb.matched);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
